// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file kt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define KT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define KT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/kt_pkg.sv =====
// Types, constants and helpers for the four-state Kalman tracker.
`timescale 1ns / 1ps

package kt_pkg;

  localparam int STATE_COUNT   = 4;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [23:0] NOISE_RESET = 24'd6554;

  // configuration register indexes
  localparam logic [0:0] REG_PROCESS_NOISE = 1'b0;
  localparam logic [0:0] REG_MEASURE_NOISE = 1'b1;

  // opcodes
  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_PREDICT = 2'd1;
  localparam logic [1:0] OP_UPDATE  = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [20:0]        time_step;
    logic signed [31:0] meas_0;
    logic signed [31:0] meas_1;
    logic signed [31:0] meas_2;
    logic signed [31:0] meas_3;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_vx;
    logic signed [31:0] est_vy;
    logic               status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PX,    // predicted estimate
    ST_PM,    // F*P
    ST_PP,    // (F*P)*F^T + Q
    ST_UA,    // innovation block
    ST_UD,    // determinant
    ST_CHK,   // singular check, |det|
    ST_UB,    // P*H^T and H*P
    ST_UN,    // gain numerators
    ST_GLD,   // divider load
    ST_GRUN,  // divider steps
    ST_GWR,   // gain write
    ST_UE,    // innovation
    ST_UP,    // covariance correction
    ST_UX,    // estimate correction
    ST_DONE
  } kt_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/kalman_tracker_4state.sv =====
// Four-state constant-velocity Kalman tracker on one shared multiply-accumulate unit.
//
//   channel | ports                        | moves
//   --------+------------------------------+------------------------------
//   in      | in_valid  in_ready  in_data  | one request: opcode, dt, meas
//   out     | out_valid out_ready out_data | estimate and status
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data | noise registers
//
// Init and unused opcodes go straight to the result, predict runs 160 MAC steps
// and a full update 136 MAC steps on the single 32x32 multiplier plus 8 gain
// divisions on a 1-bit/cycle restoring divider.
// Reset is synchronous; it clears estimate, covariance and the ready flag.
// in_ready is high only while idle; a finished result waits in the output
// register and the next request is still taken meanwhile.
`timescale 1ns / 1ps

module kalman_tracker_4state #(
  parameter int FRAC_BITS = kt_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kt_pkg::in_item_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kt_pkg::out_item_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  kt_pkg::kt_state_t state_r, state_nxt;

  logic [23:0]        qnoise_r, rnoise_r;
  logic               ready_r;
  logic signed [31:0] est_r [kt_pkg::STATE_COUNT];
  logic signed [31:0] p_r   [16];
  logic signed [31:0] m_r   [16];
  logic signed [31:0] a_r   [4];
  logic signed [31:0] n_r   [8];
  logic signed [31:0] g_r   [8];
  logic signed [31:0] e_r   [2];
  logic signed [63:0] det_r, dabs_r, acc_r;
  logic [20:0]        dt_r;
  logic signed [31:0] y0_r, y1_r;
  logic               status_r;
  logic [3:0]         o_r;
  logic [2:0]         k_r;
  logic [4:0]         dcnt_r;
  logic [63:0]        rem_r;
  logic [31:0]        quo_r;
  logic               dsat_r, dneg_r;
  logic               out_valid_r;
  kt_pkg::out_item_t  out_data_r;

  // decode
  logic [3:0]         p_idx, m_idx, o_max;
  logic [1:0]         est_idx;
  logic [2:0]         g_idx, k_max;
  logic signed [31:0] a_op, b_op;
  logic               sub, mac_en;
  logic               last_k, last_o, singular;
  logic signed [31:0] p_rd, m_rd, est_rd, g_rd;
  logic signed [63:0] prod, rterm, acc_sum;
  logic signed [31:0] sat_sum;
  logic [1:0]         ri, rj;
  logic               kb;

  // divider
  logic [31:0]        nabs;
  logic [63:0]        num;
  logic [64:0]        rem_sh;
  logic               ge;
  logic signed [31:0] gval;

  function automatic logic signed [31:0] f_val(input logic [1:0] row, input logic [1:0] col,
                                               input logic [20:0] dt);
    logic signed [31:0] v;
    if (row == col) begin
      v = ONE;
    end else if ((row == 2'd0 && col == 2'd2) || (row == 2'd1 && col == 2'd3)) begin
      v = {11'd0, dt};
    end else begin
      v = '0;
    end
    return v;
  endfunction

  assign in_ready  = (state_r == kt_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign p_rd   = p_r[p_idx];
  assign m_rd   = m_r[m_idx];
  assign est_rd = est_r[est_idx];
  assign g_rd   = g_r[g_idx];
  assign ri     = o_r[3:2];
  assign rj     = o_r[1:0];
  assign kb     = k_r[1];

  assign last_k   = (k_r == k_max);
  assign last_o   = (o_r == o_max);
  assign singular = (det_r == 64'sd0) || (rnoise_r == 24'd0);

  // shared multiply-accumulate
  assign prod    = 64'(a_op) * 64'(b_op);
  assign rterm   = (prod + HALF) >>> FRAC_BITS;
  assign acc_sum = sub ? (((k_r == 3'd0) ? 64'sd0 : acc_r) - rterm)
                       : (((k_r == 3'd0) ? 64'sd0 : acc_r) + rterm);
  assign sat_sum = kt_pkg::sat32(acc_sum);

  // divider datapath
  assign nabs   = n_r[o_r[2:0]][31] ? 32'(-n_r[o_r[2:0]]) : 32'(n_r[o_r[2:0]]);
  assign num    = ({32'd0, nabs} << FRAC_BITS) + (dabs_r >> 1);
  assign rem_sh = {rem_r, quo_r[31]};
  assign ge     = rem_sh >= {1'b0, dabs_r};
  always_comb begin
    if (dsat_r || quo_r[31]) begin
      gval = dneg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      gval = dneg_r ? -$signed(quo_r) : $signed(quo_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kt_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            kt_pkg::OP_PREDICT: state_nxt = kt_pkg::ST_PX;
            kt_pkg::OP_UPDATE:  state_nxt = kt_pkg::ST_UA;
            default:            state_nxt = kt_pkg::ST_DONE;
          endcase
        end
      end
      kt_pkg::ST_PX: if (last_k && last_o) state_nxt = kt_pkg::ST_PM;
      kt_pkg::ST_PM: if (last_k && last_o) state_nxt = kt_pkg::ST_PP;
      kt_pkg::ST_PP: if (last_k && last_o) state_nxt = kt_pkg::ST_DONE;
      kt_pkg::ST_UA: if (last_k && last_o) state_nxt = kt_pkg::ST_UD;
      kt_pkg::ST_UD: if (last_k && last_o) state_nxt = kt_pkg::ST_CHK;
      kt_pkg::ST_CHK: state_nxt = singular ? kt_pkg::ST_DONE : kt_pkg::ST_UB;
      kt_pkg::ST_UB: if (last_k && last_o) state_nxt = kt_pkg::ST_UN;
      kt_pkg::ST_UN: if (last_k && last_o) state_nxt = kt_pkg::ST_GLD;
      kt_pkg::ST_GLD: state_nxt = kt_pkg::ST_GRUN;
      kt_pkg::ST_GRUN: if (dcnt_r == 5'd31) state_nxt = kt_pkg::ST_GWR;
      kt_pkg::ST_GWR: state_nxt = (o_r == 4'd7) ? kt_pkg::ST_UE : kt_pkg::ST_GLD;
      kt_pkg::ST_UE: if (last_k && last_o) state_nxt = kt_pkg::ST_UP;
      kt_pkg::ST_UP: if (last_k && last_o) state_nxt = kt_pkg::ST_UX;
      kt_pkg::ST_UX: if (last_k && last_o) state_nxt = kt_pkg::ST_DONE;
      kt_pkg::ST_DONE: if (!out_valid_r || out_ready) state_nxt = kt_pkg::ST_IDLE;
      default: state_nxt = kt_pkg::ST_IDLE;
    endcase
  end

  // operand selection for the MAC
  always_comb begin
    p_idx   = o_r;
    m_idx   = o_r;
    est_idx = k_r[1:0];
    g_idx   = {ri, kb};
    a_op    = '0;
    b_op    = ONE;
    sub     = 1'b0;
    mac_en  = 1'b1;
    o_max   = 4'd15;
    k_max   = 3'd3;
    unique case (state_r)
      kt_pkg::ST_PX: begin
        o_max   = 4'd3;
        est_idx = k_r[1:0];
        a_op    = f_val(rj, k_r[1:0], dt_r);
        b_op    = est_rd;
      end
      kt_pkg::ST_PM: begin
        p_idx = {k_r[1:0], rj};
        a_op  = f_val(ri, k_r[1:0], dt_r);
        b_op  = p_rd;
      end
      kt_pkg::ST_PP: begin
        k_max = 3'd4;
        m_idx = {ri, k_r[1:0]};
        if (k_r == 3'd4) begin
          a_op = (ri == rj) ? {8'd0, qnoise_r} : 32'sd0;
          b_op = ONE;
        end else begin
          a_op = m_rd;
          b_op = f_val(rj, k_r[1:0], dt_r);
        end
      end
      kt_pkg::ST_UA: begin
        o_max = 4'd3;
        k_max = 3'd4;
        p_idx = {k_r[1], o_r[1], k_r[0], o_r[0]};
        if (k_r == 3'd4) begin
          a_op = (o_r[1] == o_r[0]) ? {8'd0, rnoise_r} : 32'sd0;
        end else begin
          a_op = p_rd;
        end
      end
      kt_pkg::ST_UD: begin
        o_max = 4'd0;
        k_max = 3'd1;
        sub   = k_r[0];
        a_op  = k_r[0] ? a_r[1] : a_r[0];
        b_op  = k_r[0] ? a_r[2] : a_r[3];
      end
      kt_pkg::ST_UB: begin
        k_max = 3'd1;
        p_idx = o_r[3] ? {k_r[0], o_r[2], o_r[1:0]} : {o_r[2:1], k_r[0], o_r[0]};
        a_op  = p_rd;
      end
      kt_pkg::ST_UN: begin
        o_max = 4'd7;
        k_max = 3'd1;
        sub   = k_r[0];
        m_idx = {1'b0, o_r[2:1], o_r[0] ^ k_r[0]};
        a_op  = m_rd;
        case ({o_r[0], k_r[0]})
          2'b00:   b_op = a_r[3];
          2'b01:   b_op = a_r[2];
          2'b10:   b_op = a_r[0];
          default: b_op = a_r[1];
        endcase
      end
      kt_pkg::ST_UE: begin
        o_max   = 4'd1;
        k_max   = 3'd2;
        sub     = (k_r != 3'd0);
        est_idx = {kb, o_r[0]};
        if (k_r == 3'd0) begin
          a_op = o_r[0] ? y1_r : y0_r;
        end else begin
          a_op = est_rd;
        end
      end
      kt_pkg::ST_UP: begin
        k_max = 3'd2;
        sub   = (k_r != 3'd0);
        g_idx = {ri, kb};
        m_idx = {1'b1, kb, rj};
        if (k_r == 3'd0) begin
          a_op = p_rd;
        end else begin
          a_op = g_rd;
          b_op = m_rd;
        end
      end
      kt_pkg::ST_UX: begin
        o_max   = 4'd3;
        k_max   = 3'd2;
        est_idx = rj;
        g_idx   = {rj, kb};
        if (k_r == 3'd0) begin
          a_op = est_rd;
        end else begin
          a_op = g_rd;
          b_op = e_r[kb];
        end
      end
      default: mac_en = 1'b0;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      ready_r     <= 1'b0;
      qnoise_r    <= kt_pkg::NOISE_RESET;
      rnoise_r    <= kt_pkg::NOISE_RESET;
      o_r         <= '0;
      k_r         <= '0;
      dcnt_r      <= '0;
      for (int i = 0; i < kt_pkg::STATE_COUNT; i++) est_r[i] <= '0;
      for (int i = 0; i < 16; i++) p_r[i] <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          kt_pkg::REG_PROCESS_NOISE: qnoise_r <= cfg_data;
          kt_pkg::REG_MEASURE_NOISE: rnoise_r <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == kt_pkg::ST_IDLE && in_valid) begin
        if (in_data.opcode == kt_pkg::OP_INIT) begin
          est_r[0] <= in_data.meas_0;
          est_r[1] <= in_data.meas_1;
          est_r[2] <= in_data.meas_2;
          est_r[3] <= in_data.meas_3;
          for (int i = 0; i < 16; i++) p_r[i] <= '0;
          ready_r <= 1'b1;
        end else if ((in_data.opcode == kt_pkg::OP_PREDICT ||
                      in_data.opcode == kt_pkg::OP_UPDATE) && !ready_r) begin
          for (int i = 0; i < kt_pkg::STATE_COUNT; i++) est_r[i] <= '0;
          for (int i = 0; i < 16; i++) p_r[i] <= '0;
          ready_r <= 1'b1;
        end
      end

      if (mac_en) begin
        if (last_k) begin
          k_r <= '0;
          o_r <= last_o ? 4'd0 : o_r + 4'd1;
        end else begin
          k_r <= k_r + 3'd1;
        end
        if (last_k) begin
          case (state_r)
            kt_pkg::ST_PP, kt_pkg::ST_UP: p_r[o_r] <= sat_sum;
            kt_pkg::ST_UX: est_r[rj] <= sat_sum;
            default: ;
          endcase
        end
        // predicted estimate lands once the covariance pass is done
        if (state_r == kt_pkg::ST_PP && last_k && last_o) begin
          for (int i = 0; i < kt_pkg::STATE_COUNT; i++) est_r[i] <= n_r[i];
        end
      end

      if (state_r == kt_pkg::ST_GLD) dcnt_r <= '0;
      else if (state_r == kt_pkg::ST_GRUN) dcnt_r <= dcnt_r + 5'd1;
      if (state_r == kt_pkg::ST_GWR) o_r <= (o_r == 4'd7) ? 4'd0 : o_r + 4'd1;

      if (state_r == kt_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scratch and datapath registers
  always_ff @(posedge clk) begin
    if (state_r == kt_pkg::ST_IDLE && in_valid) begin
      dt_r     <= in_data.time_step;
      y0_r     <= in_data.meas_0;
      y1_r     <= in_data.meas_1;
      status_r <= 1'b0;
    end
    if (mac_en) begin
      acc_r <= acc_sum;
      if (last_k) begin
        case (state_r)
          kt_pkg::ST_PX: n_r[{1'b0, rj}] <= sat_sum;
          kt_pkg::ST_PM, kt_pkg::ST_UB: m_r[o_r] <= sat_sum;
          kt_pkg::ST_UA: a_r[rj] <= sat_sum;
          kt_pkg::ST_UD: det_r <= acc_sum;
          kt_pkg::ST_UN: n_r[o_r[2:0]] <= sat_sum;
          kt_pkg::ST_UE: e_r[o_r[0]] <= sat_sum;
          default: ;
        endcase
      end
    end
    if (state_r == kt_pkg::ST_CHK) begin
      dabs_r <= det_r[63] ? -det_r : det_r;
      if (singular) status_r <= 1'b1;
    end
    if (state_r == kt_pkg::ST_GLD) begin
      rem_r  <= {32'd0, num[63:32]};
      quo_r  <= num[31:0];
      dsat_r <= {32'd0, num[63:32]} >= dabs_r;
      dneg_r <= n_r[o_r[2:0]][31] ^ det_r[63];
    end
    if (state_r == kt_pkg::ST_GRUN) begin
      rem_r <= ge ? 64'(rem_sh - {1'b0, dabs_r}) : rem_sh[63:0];
      quo_r <= {quo_r[30:0], ge};
    end
    if (state_r == kt_pkg::ST_GWR) g_r[o_r[2:0]] <= gval;
    if (state_r == kt_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_data_r.est_x  <= est_r[0];
      out_data_r.est_y  <= est_r[1];
      out_data_r.est_vx <= est_r[2];
      out_data_r.est_vy <= est_r[3];
      out_data_r.status <= status_r;
    end
  end

endmodule

// ===== sv/kt_checker.sv =====
// Port-level checks for the Kalman tracker, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input kt_pkg::out_item_t out_data
);

  `KT_ASSERT(a_busy_after_req, (in_valid && in_ready) |=> !in_ready, "ready right after request")
  `KT_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")
  `KT_ASSERT(a_out_stable, (out_valid && !out_ready) |=> $stable(out_data), "result changed while stalled")
  `KT_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid, "result shown after reset")

endmodule

bind kalman_tracker_4state kt_checker u_kt_checker (.*);
